// File: design/length_typed_packet_deframer_core_assert.svh
// assertion macros used by the deframer core
`ifndef LENGTH_TYPED_PACKET_DEFRAMER_CORE_ASSERT_SVH
`define LENGTH_TYPED_PACKET_DEFRAMER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LTPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("deframer check failed");

// next-cycle implication, disabled during reset
`define LTPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

// File: design/ltpd_pkg.sv
package ltpd_pkg;

  // status codes of one result word
  localparam logic [1:0] ST_BUSY   = 2'd0;
  localparam logic [1:0] ST_GOOD   = 2'd1;
  localparam logic [1:0] ST_BADSUM = 2'd2;
  localparam logic [1:0] ST_STRAY  = 2'd3;

  // framing state carried between words
  typedef struct packed {
    logic       in_packet;
    logic       length_seen;
    logic [2:0] type_code;
    logic       data_done;
    logic [7:0] declared_length;
    logic [7:0] data_count;
    logic [7:0] running_sum;
  } ltpd_state_t;

  // one result word
  typedef struct packed {
    logic [1:0] status;
    logic [2:0] packet_type;
    logic [7:0] packet_length;
    logic       data_valid;
    logic [7:0] data_index;
    logic [7:0] data_byte;
  } ltpd_result_t;

endpackage

// File: design/ltpd_step.sv
module ltpd_step import ltpd_pkg::*; (
  input  ltpd_state_t  state,
  input  logic [7:0]   head_byte,
  input  logic [7:0]   rx_byte,
  output ltpd_state_t  state_nxt,
  output ltpd_result_t result
);

  logic [8:0] count_inc;

  assign count_inc = {1'b0, state.data_count} + 9'd1;

  // per-byte framing decision
  always_comb begin
    state_nxt = state;
    result    = '0;
    result.status = ST_BUSY;
    if (!state.in_packet) begin
      // idle: look for the head byte
      if (rx_byte == head_byte) begin
        state_nxt.in_packet   = 1'b1;
        state_nxt.length_seen = 1'b0;
        state_nxt.type_code   = 3'd0;
        state_nxt.data_done   = 1'b0;
        state_nxt.data_count  = 8'd0;
        state_nxt.running_sum = 8'd0;
      end else begin
        result.status = ST_STRAY;
      end
    end else begin
      if (!state.length_seen) begin
        state_nxt.length_seen     = 1'b1;
        state_nxt.declared_length = rx_byte;
      end else if (state.type_code == 3'd0) begin
        // a zero type means the next byte is the type again
        state_nxt.type_code = rx_byte[2:0];
      end else if (!state.data_done && state.declared_length != 8'd0) begin
        // payload byte
        result.data_valid     = 1'b1;
        result.data_index     = state.data_count;
        result.data_byte      = rx_byte;
        state_nxt.running_sum = state.running_sum + rx_byte;
        if (count_inc >= {1'b0, state.declared_length}) begin
          state_nxt.data_done = 1'b1;
        end
        state_nxt.data_count = count_inc[7:0];
      end else begin
        // checksum byte
        result.status = (rx_byte == state.running_sum) ? ST_GOOD : ST_BADSUM;
      end
      result.packet_type   = state_nxt.type_code;
      result.packet_length = state_nxt.length_seen ? state_nxt.declared_length : 8'd0;
      // end of packet keeps length and sum until the next head
      if (result.status != ST_BUSY) begin
        state_nxt.in_packet   = 1'b0;
        state_nxt.length_seen = 1'b0;
        state_nxt.type_code   = 3'd0;
        state_nxt.data_done   = 1'b0;
        state_nxt.data_count  = 8'd0;
      end
    end
  end

endmodule

// File: design/length_typed_packet_deframer_core.sv
// Packet deframer for a byte stream from a serial receiver.
// Input channel (in_valid / in_stall / in_rx_byte): one received byte per
// word. A packet is head byte, length byte, type byte (repeated while its
// low three bits are zero), length payload bytes, then an 8-bit sum byte.
// Result channel (out_valid / out_stall / out_*): exactly one result word
// per input byte: status, packet type and length, and the payload byte with
// its index when out_data_valid is set.
// Config channel (cfg_valid / cfg_ready / cfg_data): writes the head byte;
// cfg_ready is always high. Write only while no packet traffic is pending.
// Latency: the result for a byte is presented the cycle after it is taken.
// Throughput: one byte per cycle while out_stall holds no result; the state
// update between the framing state register and the result register is combinational.
// Stall: while a result waits under out_stall, in_stall is raised so the
// result register holds; a waiting result is replaced in the cycle it is
// taken, so back-to-back bytes flow with no bubble.
// Reset (rst_n low, synchronous): idle, head byte 0, no result pending.
module length_typed_packet_deframer_core import ltpd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic [2:0] out_packet_type,
  output logic [7:0] out_packet_length,
  output logic       out_data_valid,
  output logic [7:0] out_data_index,
  output logic [7:0] out_data_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

`include "length_typed_packet_deframer_core_assert.svh"

  logic         in_accept;
  logic [7:0]   head_r;
  ltpd_state_t  state_r;
  ltpd_state_t  state_nxt;
  ltpd_result_t result_r;
  ltpd_result_t result_nxt;
  logic         out_valid_r;

  // handshake
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  // head byte register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= 8'd0;
    end else if (cfg_valid) begin
      head_r <= cfg_data;
    end
  end

  // per-byte framing logic
  ltpd_step u_step (
    .state     (state_r),
    .head_byte (head_r),
    .rx_byte   (in_rx_byte),
    .state_nxt (state_nxt),
    .result    (result_nxt)
  );

  // framing state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        state_r <= state_nxt;
      end
      if (in_accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = result_r.status;
  assign out_packet_type   = result_r.packet_type;
  assign out_packet_length = result_r.packet_length;
  assign out_data_valid    = result_r.data_valid;
  assign out_data_index    = result_r.data_index;
  assign out_data_byte     = result_r.data_byte;

  // checks
  `LTPD_ASSERT_NOW(a_data_busy, clk, rst_n, out_valid_r && result_r.data_valid,
    result_r.status == ST_BUSY)
  `LTPD_ASSERT_NOW(a_data_in_len, clk, rst_n, out_valid_r && result_r.data_valid,
    result_r.data_index < result_r.packet_length)
  `LTPD_ASSERT_NOW(a_type_after_len, clk, rst_n, state_r.type_code != 3'd0,
    state_r.in_packet && state_r.length_seen)
  `LTPD_ASSERT_NEXT(a_end_idle, clk, rst_n, in_accept && result_nxt.status != ST_BUSY,
    !state_r.in_packet)

endmodule

// File: tb/length_typed_packet_deframer_core_test.sv
module length_typed_packet_deframer_core_test import ltpd_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_status;
  logic [2:0] out_packet_type;
  logic [7:0] out_packet_length;
  logic       out_data_valid;
  logic [7:0] out_data_index;
  logic [7:0] out_data_byte;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'h00;

  // bytes waiting to be sent and status reports waiting to come back
  logic [7:0]   rx_backlog[$];
  ltpd_result_t frame_reports[$];

  // framing state and head byte as the deframer should hold them
  ltpd_state_t  frame = '0;
  logic [7:0]   head_value = 8'h00;

  int unsigned  sender_idle_pct = 0;
  int unsigned  stall_pct = 0;
  int unsigned  bytes_queued = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;
  bit           in_taken = 1'b0;

  length_typed_packet_deframer_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_packet_type   (out_packet_type),
    .out_packet_length (out_packet_length),
    .out_data_valid    (out_data_valid),
    .out_data_index    (out_data_index),
    .out_data_byte     (out_data_byte),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // one received byte through the framing state, returns its status report
  function automatic ltpd_result_t deframe_byte(input logic [7:0] b);
    ltpd_result_t r;
    r = '0;
    r.status = ST_BUSY;
    if (!frame.in_packet) begin
      if (b == head_value) begin
        frame.in_packet   = 1'b1;
        frame.length_seen = 1'b0;
        frame.type_code   = 3'd0;
        frame.data_done   = 1'b0;
        frame.data_count  = 8'd0;
        frame.running_sum = 8'd0;
      end else begin
        r.status = ST_STRAY;
      end
    end else begin
      if (!frame.length_seen) begin
        frame.length_seen     = 1'b1;
        frame.declared_length = b;
      end else if (frame.type_code == 3'd0) begin
        frame.type_code = b[2:0];
      end else if (!frame.data_done && frame.declared_length != 8'd0) begin
        r.data_valid = 1'b1;
        r.data_index = frame.data_count;
        r.data_byte  = b;
        frame.running_sum = frame.running_sum + b;
        if ({1'b0, frame.data_count} + 9'd1 >= {1'b0, frame.declared_length})
          frame.data_done = 1'b1;
        frame.data_count = frame.data_count + 8'd1;
      end else begin
        r.status = (b == frame.running_sum) ? ST_GOOD : ST_BADSUM;
      end
      r.packet_type   = frame.type_code;
      r.packet_length = frame.length_seen ? frame.declared_length : 8'd0;
      // end of packet back to idle, length and sum kept
      if (r.status != ST_BUSY) begin
        frame.in_packet   = 1'b0;
        frame.length_seen = 1'b0;
        frame.type_code   = 3'd0;
        frame.data_done   = 1'b0;
        frame.data_count  = 8'd0;
      end
    end
    return r;
  endfunction

  // byte driver and receiver stall, both on the falling edge
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (rx_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_rx_byte <= rx_backlog.pop_front();
        in_valid   <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // monitor: check result words, predict accepted bytes, track head writes
  always @(posedge clk) begin
    ltpd_result_t got;
    ltpd_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.status        = out_status;
        got.packet_type   = out_packet_type;
        got.packet_length = out_packet_length;
        got.data_valid    = out_data_valid;
        got.data_index    = out_data_index;
        got.data_byte     = out_data_byte;
        if (frame_reports.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result word with nothing pending: st=%0d ty=%0d len=%0d dv=%0d",
                     got.status, got.packet_type, got.packet_length, got.data_valid);
        end else begin
          want = frame_reports.pop_front();
          if (got.status !== want.status || got.packet_type !== want.packet_type ||
              got.packet_length !== want.packet_length ||
              got.data_valid !== want.data_valid ||
              got.data_index !== want.data_index || got.data_byte !== want.data_byte) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch exp: st=%0d ty=%0d len=%0d dv=%0d idx=%0d byte=%02h",
                       want.status, want.packet_type, want.packet_length,
                       want.data_valid, want.data_index, want.data_byte);
              $display("         got: st=%0d ty=%0d len=%0d dv=%0d idx=%0d byte=%02h",
                       got.status, got.packet_type, got.packet_length,
                       got.data_valid, got.data_index, got.data_byte);
            end
          end
        end
      end
      in_taken = in_valid && !in_stall;
      if (in_taken)
        frame_reports.push_back(deframe_byte(in_rx_byte));
      if (cfg_valid && cfg_ready)
        head_value = cfg_data;
    end else begin
      in_taken = 1'b0;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    rx_backlog.push_back(b);
    bytes_queued++;
  endtask

  // one packet, optionally with a bad sum or cut short after keep bytes
  task automatic queue_packet(input logic [7:0] head, input int unsigned len,
                              input int unsigned zero_types, input bit corrupt,
                              input int unsigned keep);
    logic [7:0] pkt[$];
    logic [7:0] sum;
    logic [7:0] d;
    int unsigned n;
    sum = 8'd0;
    pkt.push_back(head);
    pkt.push_back(len[7:0]);
    repeat (zero_types) pkt.push_back({5'($urandom_range(31)), 3'd0});
    pkt.push_back({5'($urandom_range(31)), 3'($urandom_range(1, 7))});
    repeat (len) begin
      d = 8'($urandom_range(255));
      sum = sum + d;
      pkt.push_back(d);
    end
    if (corrupt)
      pkt.push_back(sum ^ 8'($urandom_range(1, 255)));
    else
      pkt.push_back(sum);
    n = (keep != 0 && keep < pkt.size()) ? keep : pkt.size();
    for (int unsigned i = 0; i < n; i++)
      send_byte(pkt[i]);
  endtask

  // wait until every byte is sent and every report has come back
  task automatic wait_drained;
    while (rx_backlog.size() != 0 || in_valid || frame_reports.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_head(input logic [7:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mix of well-formed packets, noise and broken packets
  task automatic queue_traffic(input logic [7:0] head, input int unsigned count);
    int unsigned start;
    int unsigned r;
    int unsigned l;
    int unsigned len;
    start = bytes_queued;
    while (bytes_queued - start < count) begin
      r = $urandom_range(99);
      l = $urandom_range(99);
      if (l < 10)
        len = 0;
      else if (l < 12)
        len = $urandom_range(20, 60);
      else
        len = $urandom_range(1, 10);
      if (r < 70) begin
        queue_packet(head, len, ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0,
                     ($urandom_range(9) == 0), 0);
      end else if (r < 85) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
      end else begin
        queue_packet(head, len, $urandom_range(1), 1'($urandom_range(1)),
                     $urandom_range(1, len + 3));
      end
    end
  endtask

  // one phase: new head byte, new idle and stall percentages, an optional longest packet, a full pause halfway through
  task automatic run_phase(input logic [7:0] head, input int unsigned idle,
                           input int unsigned stall, input int unsigned count,
                           input bit longest);
    wait_drained();
    write_head(head);
    sender_idle_pct = idle;
    stall_pct = stall;
    if (longest)
      queue_packet(head, 255, 0, 1'b0, 0);
    queue_traffic(head, count / 2);
    wait_drained();
    queue_traffic(head, count - count / 2);
  endtask

  // stimulus sequence
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed bytes with the reset head byte of zero
    send_byte(8'hFF);
    // zero length, zero type bits twice, head value reused as length and type
    send_byte(8'h00); send_byte(8'h00); send_byte(8'h00); send_byte(8'hF8);
    send_byte(8'h07); send_byte(8'h00);
    // two data bytes with wrapping sum
    send_byte(8'h00); send_byte(8'h02); send_byte(8'hFD); send_byte(8'hFF);
    send_byte(8'h01); send_byte(8'h00);
    // checksum failure
    send_byte(8'h00); send_byte(8'h01); send_byte(8'h01); send_byte(8'h80);
    send_byte(8'h81);
    // head value as data byte
    send_byte(8'h00); send_byte(8'h03); send_byte(8'h0A); send_byte(8'h00);
    send_byte(8'h55); send_byte(8'hAA); send_byte(8'hFF);

    run_phase(8'hFF, 0, 0, 350, 1'b1);
    run_phase(8'h00, 81, 0, 350, 1'b0);
    run_phase(8'($urandom_range(1, 254)), 0, 81, 350, 1'b1);
    run_phase(8'h5A, 32, 32, 350, 1'b0);

    wait_drained();
    mismatch_count += frame_reports.size();
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
